// ----- sv/stlenv_pkg.sv -----
// ----------------------------------------------------------------------------
// stlenv_pkg
// Shared constants, register codes and sine table math for the stereo tone
// generator with linear envelope.
// ----------------------------------------------------------------------------
package stlenv_pkg;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = 32;
    localparam int LEN_W      = 24;
    localparam int LEVEL_W    = 15;
    localparam int SAMPLE_W   = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_END_LEVEL   = 3'd6;

    // reset values
    localparam logic [STEP_W-1:0]  RST_STEP       = 32'd50960225;
    localparam logic [LEN_W-1:0]   RST_ATTACK_LEN = 24'd4410;
    localparam logic [LEN_W-1:0]   RST_TOTAL_LEN  = 24'd110250;
    localparam logic [LEVEL_W-1:0] RST_PEAK_LEVEL = 15'd32760;

    // quarter turn in Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Q30 sine by Taylor series to x^13, truncating each term
    function automatic longint sin_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;    sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;   sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;   sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;  sum = sum + longint'(term);
        return (sum < 0) ? 64'sd0 : sum;
    endfunction

    // Q1.15 table entry from a quarter-wave angle and the quadrant
    function automatic logic signed [SAMPLE_W-1:0] sine_entry(
        input longint unsigned angle,
        input longint unsigned quad
    );
        longint s;
        longint v;
        s = sin_q30(angle);
        v = (s * 32767 + (64'sd1 <<< 29)) >>> 30;
        if (v > 32767) v = 32767;
        if (quad >= 2) v = -v;
        return SAMPLE_W'(v);
    endfunction

endpackage

// ----- sv/stlenv_div.sv -----
// ----------------------------------------------------------------------------
// stlenv_div
// Bit-serial restoring divider: one quotient bit per cycle, NUM_W quotient bits.
// ----------------------------------------------------------------------------
module stlenv_div #(
    parameter int NUM_W = 39,
    parameter int DEN_W = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0] n_rem_sh;
    logic           n_fit;

    // shift in the next numerator bit and trial subtract
    assign n_rem_sh = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign n_fit    = (n_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_rem <= n_fit ? (n_rem_sh - {1'b0, r_den}) : n_rem_sh;
                r_quo <= {r_quo[NUM_W-2:0], n_fit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- sv/stlenv_rom.sv -----
// ----------------------------------------------------------------------------
// stlenv_rom
// Full-period Q1.15 sine table with two registered read ports.
// ----------------------------------------------------------------------------
module stlenv_rom
    import stlenv_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  logic                       i_clk,
    input  logic [$clog2(ENTRIES)-1:0] i_addr_a,
    input  logic [$clog2(ENTRIES)-1:0] i_addr_b,
    output logic signed [SAMPLE_W-1:0] o_data_a,
    output logic signed [SAMPLE_W-1:0] o_data_b
);

    logic signed [SAMPLE_W-1:0] rom [ENTRIES];

    // table contents fixed at elaboration
    for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
        localparam longint unsigned QUAD  = (4 * k) / ENTRIES;
        localparam longint unsigned REM   = (4 * k) % ENTRIES;
        localparam longint unsigned STEPS = (QUAD % 2 == 1) ? (ENTRIES - REM) : REM;
        localparam longint unsigned ANGLE = (STEPS * HALF_PI_Q30) / ENTRIES;
        assign rom[k] = sine_entry(ANGLE, QUAD);
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        o_data_a <= rom[i_addr_a];
        o_data_b <= rom[i_addr_b];
    end

endmodule

// ----- sv/stereo_tone_with_linear_envelope_unit.sv -----
// ----------------------------------------------------------------------------
// stereo_tone_with_linear_envelope_unit
// Two phase-accumulator tones shaped by a linear attack/decline envelope.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): each request carries i_restart and
//   produces exactly one stereo sample on the output channel
//   (o_valid / i_stall). i_restart = 1 starts the note over at sample zero.
//   Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_data
//   while no request is in flight.
// Sequence:
//   A sounding sample passes through S_START, S_DIV, S_MUL and S_OUT after
//   accept; S_DIV waits on the bit-serial envelope divider, which produces
//   one quotient bit per cycle. A request after the note ends goes from
//   S_IDLE straight to S_OUT. One request is worked on at a time; the next
//   is accepted the cycle after the result enters the output register.
// Reset: synchronous, active low; registers take their default values and
//   the note index and phases go to zero.
// Stall: a result waits in the output register while i_stall is high; the
//   block finishes the next request and holds it until the register frees.
// ----------------------------------------------------------------------------
module stereo_tone_with_linear_envelope_unit
    import stlenv_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = 1024,
    parameter int PHASE_BITS         = 32,
    parameter int COUNT_BITS         = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    // input channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_restart,
    // output channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_left_sample,
    output logic signed [SAMPLE_W-1:0] o_right_sample,
    output logic                       o_last,
    output logic                       o_active
);

    localparam int CW   = COUNT_BITS;
    localparam int PB   = PHASE_BITS;
    localparam int NW   = CW + LEVEL_W;
    localparam int AW   = $clog2(SINE_TABLE_ENTRIES);
    localparam int IXW  = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int PW   = 16 + IXW;
    localparam logic [32:0] COUNT_MAX = (33'd1 << CW) - 33'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_MUL,
        S_OUT
    } t_state;

    // configuration registers
    logic [STEP_W-1:0]  r_lstep, r_rstep;
    logic [LEN_W-1:0]   r_attack, r_total;
    logic [LEVEL_W-1:0] r_peak, r_start_lvl, r_end_lvl;

    // note state
    logic [CW-1:0] r_idx;
    logic [PB-1:0] r_lphase, r_rphase;

    // work registers
    t_state              r_state;
    logic [NW-1:0]       r_num;
    logic [CW-1:0]       r_den;
    logic [LEVEL_W-1:0]  r_from;
    logic                r_neg;
    logic                r_last;
    logic                r_zero;
    logic [AW-1:0]       r_laddr, r_raddr;
    logic [LEVEL_W-1:0]  r_env;
    logic signed [31:0]  r_lprod, r_rprod;

    // output register
    logic                       r_ovalid;
    logic signed [SAMPLE_W-1:0] r_lout, r_rout;
    logic                       r_olast, r_oactive;

    // datapath signals
    logic                accept;
    logic [CW-1:0]       n_i;
    logic [PB-1:0]       n_lph, n_rph;
    logic [32:0]         t33, a33;
    logic [CW-1:0]       t_len, a_len;
    logic                in_attack;
    logic [LEVEL_W-1:0]  from_lvl, to_lvl, mag;
    logic [CW-1:0]       pos, len;
    logic [PW-1:0]       lprod_ix, rprod_ix;
    logic [IXW-1:0]      lix, rix;
    logic                div_done;
    logic [NW-1:0]       quo;
    logic signed [SAMPLE_W-1:0] rom_l, rom_r;
    logic signed [SAMPLE_W-1:0] n_lsamp, n_rsamp;
    logic                out_free;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_ovalid || !i_stall;

    // restart applies before the sample is formed
    assign n_i   = i_restart ? '0 : r_idx;
    assign n_lph = i_restart ? '0 : r_lphase;
    assign n_rph = i_restart ? '0 : r_rphase;

    // clamp lengths to the counter range and the attack to the note
    always_comb begin
        t33   = (33'(r_total) > COUNT_MAX) ? COUNT_MAX : 33'(r_total);
        a33   = (33'(r_attack) > t33) ? t33 : 33'(r_attack);
        t_len = CW'(t33);
        a_len = CW'(a33);
    end

    // ramp operands
    always_comb begin
        in_attack = (n_i < a_len);
        if (in_attack) begin
            from_lvl = r_start_lvl;
            to_lvl   = r_peak;
            pos      = n_i;
            len      = a_len;
        end else begin
            from_lvl = r_peak;
            to_lvl   = r_end_lvl;
            pos      = n_i - a_len;
            len      = t_len - a_len;
        end
        mag = (to_lvl < from_lvl) ? (from_lvl - to_lvl) : (to_lvl - from_lvl);
    end

    // table index from the phase top bits
    always_comb begin
        lprod_ix = PW'(n_lph[PB-1 -: 16]) * PW'(SINE_TABLE_ENTRIES);
        rprod_ix = PW'(n_rph[PB-1 -: 16]) * PW'(SINE_TABLE_ENTRIES);
        lix = lprod_ix[PW-1:16];
        rix = rprod_ix[PW-1:16];
        if (lix >= IXW'(SINE_TABLE_ENTRIES)) lix = IXW'(SINE_TABLE_ENTRIES - 1);
        if (rix >= IXW'(SINE_TABLE_ENTRIES)) rix = IXW'(SINE_TABLE_ENTRIES - 1);
    end

    // scale back by 2^15, truncating toward zero
    function automatic logic signed [SAMPLE_W-1:0] scale(input logic signed [31:0] p);
        logic [31:0] m;
        logic [31:0] s;
        m = p[31] ? 32'(-p) : 32'(p);
        s = m >> 15;
        return p[31] ? SAMPLE_W'(-s) : SAMPLE_W'(s);
    endfunction

    assign n_lsamp = scale(r_lprod);
    assign n_rsamp = scale(r_rprod);

    stlenv_div #(
        .NUM_W (NW),
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    stlenv_rom #(
        .ENTRIES (SINE_TABLE_ENTRIES)
    ) u_rom (
        .i_clk    (i_clk),
        .i_addr_a (r_laddr),
        .i_addr_b (r_raddr),
        .o_data_a (rom_l),
        .o_data_b (rom_r)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lstep     <= RST_STEP;
            r_rstep     <= RST_STEP;
            r_attack    <= RST_ATTACK_LEN;
            r_total     <= RST_TOTAL_LEN;
            r_peak      <= RST_PEAK_LEVEL;
            r_start_lvl <= '0;
            r_end_lvl   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_LEFT_STEP:   r_lstep     <= i_cfg_data[STEP_W-1:0];
                CFG_RIGHT_STEP:  r_rstep     <= i_cfg_data[STEP_W-1:0];
                CFG_ATTACK_LEN:  r_attack    <= i_cfg_data[LEN_W-1:0];
                CFG_TOTAL_LEN:   r_total     <= i_cfg_data[LEN_W-1:0];
                CFG_PEAK_LEVEL:  r_peak      <= i_cfg_data[LEVEL_W-1:0];
                CFG_START_LEVEL: r_start_lvl <= i_cfg_data[LEVEL_W-1:0];
                CFG_END_LEVEL:   r_end_lvl   <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_lphase <= '0;
            r_rphase <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // output drains unless a new result is loaded below
            if (r_ovalid && !i_stall && (r_state != S_OUT)) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_laddr <= AW'(lix);
                        r_raddr <= AW'(rix);
                        r_num   <= NW'(mag) * NW'(pos);
                        r_den   <= len;
                        r_from  <= from_lvl;
                        r_neg   <= (to_lvl < from_lvl);
                        r_last  <= (n_i == t_len - 1'b1);
                        if (n_i >= t_len) begin
                            // after the note: zeros, state holds
                            r_zero   <= 1'b1;
                            r_idx    <= n_i;
                            r_lphase <= n_lph;
                            r_rphase <= n_rph;
                            r_state  <= S_OUT;
                        end else begin
                            r_zero   <= 1'b0;
                            r_idx    <= n_i + 1'b1;
                            r_lphase <= n_lph + PB'(r_lstep);
                            r_rphase <= n_rph + PB'(r_rstep);
                            r_state  <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_env   <= r_neg ? (r_from - quo[LEVEL_W-1:0])
                                         : (r_from + quo[LEVEL_W-1:0]);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_lprod <= 32'(signed'({1'b0, r_env})) * 32'(rom_l);
                    r_rprod <= 32'(signed'({1'b0, r_env})) * 32'(rom_r);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_lout    <= r_zero ? '0 : n_lsamp;
                        r_rout    <= r_zero ? '0 : n_rsamp;
                        r_olast   <= !r_zero && r_last;
                        r_oactive <= !r_zero;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_left_sample  = r_lout;
    assign o_right_sample = r_rout;
    assign o_last         = r_olast;
    assign o_active       = r_oactive;

endmodule

// ----- verif/stereo_tone_with_linear_envelope_unit_test.sv -----
// ----------------------------------------------------------------------------
// stereo_tone_with_linear_envelope_unit_test
// Drives restart/advance requests through the tone unit under several register
// settings, predicts each stereo sample from its own sine table and envelope
// math, and compares every returned sample field by field, in order.
// ----------------------------------------------------------------------------
module stereo_tone_with_linear_envelope_unit_test
    import stlenv_pkg::*;
();

    localparam int  TABLE_N   = 1024;
    localparam int  RANDOM_N  = 520;
    localparam int  SETTLE_CY = 64;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
        logic                       active;
    } t_sample;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_restart;
    logic                  o_valid;
    logic                  i_stall;
    logic signed [SAMPLE_W-1:0] o_left_sample;
    logic signed [SAMPLE_W-1:0] o_right_sample;
    logic                  o_last;
    logic                  o_active;

    stereo_tone_with_linear_envelope_unit u_dut (.*);

    // predictor state and register shadows
    logic signed [15:0] tone_rom [TABLE_N];
    logic [31:0] left_step, right_step, left_acc, right_acc;
    logic [23:0] attack_len, note_len, note_pos;
    logic [14:0] peak_lvl, start_lvl, end_lvl;

    t_sample expected_samples[$];
    int      error_count = 0;
    int      sample_count = 0;
    int      note_end_count = 0;
    int      stall_left = 0;
    bit      hold_off;
    bit      any_stall;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("FAILED: results differ");
        $finish;
    end

    // sine table built independently from the quarter-wave Taylor series
    function automatic longint taylor_sin(longint unsigned x);
        longint unsigned x2, term;
        longint          acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        return (acc < 0) ? 0 : acc;
    endfunction

    task automatic build_tone_rom();
        longint unsigned quad, r, steps;
        longint v;
        for (int k = 0; k < TABLE_N; k++) begin
            quad  = (4 * k) / TABLE_N;
            r     = (4 * k) % TABLE_N;
            steps = quad[0] ? (TABLE_N - r) : r;
            v = (taylor_sin(steps * HALF_PI_Q30 / TABLE_N) * 32767 + (64'sd1 <<< 29)) >>> 30;
            if (v > 32767) v = 32767;
            tone_rom[k] = 16'((quad >= 2) ? -v : v);
        end
    endtask

    function automatic longint ramp_level(longint from, longint to,
                                          longint unsigned pos, longint unsigned len);
        longint          d;
        longint unsigned q;
        d = to - from;
        q = ((d < 0 ? -d : d) * pos) / len;
        return (d < 0) ? from - longint'(q) : from + longint'(q);
    endfunction

    function automatic logic signed [15:0] shape(longint env, logic signed [15:0] s);
        longint p;
        p = env * longint'(s);
        return 16'((p < 0) ? -((-p) >>> 15) : (p >>> 15));
    endfunction

    // next stereo sample for one request; advances the note
    function automatic t_sample next_sample(bit restart);
        t_sample r;
        longint unsigned t, a, i;
        longint env;
        if (restart) begin
            note_pos  = '0;
            left_acc  = '0;
            right_acc = '0;
        end
        t = note_len;
        a = (attack_len > t) ? t : attack_len;
        i = note_pos;
        r = '0;
        if (i >= t) return r;
        if (i < a) env = ramp_level(start_lvl, peak_lvl, i, a);
        else env = ramp_level(peak_lvl, end_lvl, i - a, t - a);
        r.left   = shape(env, tone_rom[(longint'(left_acc[31:16]) * TABLE_N) >> 16]);
        r.right  = shape(env, tone_rom[(longint'(right_acc[31:16]) * TABLE_N) >> 16]);
        r.last   = (i + 1 == t);
        r.active = 1'b1;
        note_pos  = note_pos + 1;
        left_acc  = left_acc + left_step;
        right_acc = right_acc + right_step;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("mismatch at sample %0d: %s got %0d want %0d", sample_count, what, got, want);
    endtask

    // send one request and record its prediction when accepted;
    // valid stays up until the next request or an idle call
    task automatic send_request(bit restart);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (o_stall);
        expected_samples.push_back(next_sample(restart));
    endtask

    task automatic idle_input();
        i_valid <= 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_LEFT_STEP:   left_step  = val;
            CFG_RIGHT_STEP:  right_step = val;
            CFG_ATTACK_LEN:  attack_len = val[23:0];
            CFG_TOTAL_LEN:   note_len   = val[23:0];
            CFG_PEAK_LEVEL:  peak_lvl   = val[14:0];
            CFG_START_LEVEL: start_lvl  = val[14:0];
            CFG_END_LEVEL:   end_lvl    = val[14:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        idle_input();
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CY) @(posedge i_clk);
    endtask

    task automatic set_note(logic [31:0] ls, logic [31:0] rs, logic [23:0] al,
                            logic [23:0] tl, logic [14:0] pk, logic [14:0] st,
                            logic [14:0] en);
        drain();
        write_reg(CFG_LEFT_STEP, ls);
        write_reg(CFG_RIGHT_STEP, rs);
        write_reg(CFG_ATTACK_LEN, al);
        write_reg(CFG_TOTAL_LEN, tl);
        write_reg(CFG_PEAK_LEVEL, pk);
        write_reg(CFG_START_LEVEL, st);
        write_reg(CFG_END_LEVEL, en);
        i_cfg_wr_en <= 1'b0;
    endtask

    // defaults out of reset, then extremes: empty note, clamped attack
    task automatic test_directed();
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        set_note(32'd0, 32'hFFFF_FFFF, 24'd2, 24'd0, 15'h7FFF, 15'd0, 15'h7FFF);
        send_request(1'b1);
        send_request(1'b0);
        set_note(32'h8000_0000, 32'h4000_0000, 24'hFF_FFFF, 24'd5,
                 15'h7FFF, 15'h7FFF, 15'd0);
        repeat (7) send_request(1'b0);
        send_request(1'b1);
        set_note(32'hFFFF_FFFF, 32'h0123_4567, 24'd3, 24'd8, 15'd0, 15'h7FFF, 15'h7FFF);
        send_request(1'b1);
        repeat (9) send_request(1'b0);
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        set_note(32'h0765_4321, 32'h1234_5678, 24'd4, 24'd30, 15'd20000, 15'd100, 15'd50);
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (6) send_request(1'b0);
        join
    endtask

    // short random notes, mostly advancing with occasional restarts
    task automatic test_random();
        for (int n = 0; n < RANDOM_N; n++) begin
            if (n % 65 == 0)
                set_note($urandom, $urandom, 24'($urandom_range(0, 20)),
                         24'($urandom_range(0, 40)), 15'($urandom), 15'($urandom),
                         15'($urandom));
            send_request($urandom_range(0, 19) == 0);
        end
    endtask

    // receiver stall and result checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                t_sample want;
                sample_count++;
                stall_left = $urandom_range(0, 10);
                if (expected_samples.size() == 0) begin
                    report_mismatch("unexpected sample", 0, 0);
                end else begin
                    want = expected_samples.pop_front();
                    if (o_left_sample !== want.left)
                        report_mismatch("left", o_left_sample, want.left);
                    if (o_right_sample !== want.right)
                        report_mismatch("right", o_right_sample, want.right);
                    if (o_last !== want.last) report_mismatch("last", o_last, want.last);
                    if (o_active !== want.active)
                        report_mismatch("active", o_active, want.active);
                    if (want.last) note_end_count++;
                end
            end
            if (hold_off) begin
                i_stall <= 1'b1;
                any_stall = 1'b1;
            end else if (stall_left != 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_restart   = 1'b0;
        hold_off    = 1'b0;
        left_step  = RST_STEP;
        right_step = RST_STEP;
        attack_len = RST_ATTACK_LEN;
        note_len   = RST_TOTAL_LEN;
        peak_lvl   = RST_PEAK_LEVEL;
        start_lvl  = '0;
        end_lvl    = '0;
        note_pos   = '0;
        left_acc   = '0;
        right_acc  = '0;
        build_tone_rom();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random();
        drain();

        $display("covered %0d samples, %0d note ends, held output %0s",
                 sample_count, note_end_count, any_stall ? "yes" : "no");
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
